### rtl/deq_pkg.sv
// Package for the double-ended queue ring unit.
// Holds the item kind and result status codes, the controller state type and
// the command/status structs shared by the controller and the datapath.
package deq_pkg;

    // Item kinds carried on the input tuser
    localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [2:0] KIND_POP_BACK   = 3'd3;
    localparam logic [2:0] KIND_LIST       = 3'd4;

    // Result status codes carried on the output tuser
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FETCH,
        ST_LIST_RD,
        ST_LIST_OUT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic ready;     // input side may take a transaction
        logic take;      // capture the input item
        logic exec;      // execute the captured item
        logic fetch;     // finish a pop with the fetched end value
        logic list_rd;   // read the next listed element
        logic list_emit; // emit the listed element
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;  // output register can load this cycle
        logic op_fetch;  // pop leaves elements, new end value must be read
        logic op_list;   // list over a non-empty store
        logic list_last; // current listed element is the back one
    } sts_t;

endpackage

### rtl/double_ended_queue_ring_unit.sv
// Top level of the double-ended queue ring unit: stream ports, controller
// and datapath. Depends on deq_pkg, deq_ctrl and deq_datapath.
//
//   channel  | direction | tuser        | tdata                                | tlast
//   s_axis   | in        | kind [2:0]   | data_in [31:0]                       | -
//   m_axis   | out       | status [1:0] | data_out, fill_count, front, back    | run_end
//
// Steps: push, rejected pop/push, empty list and unused kinds are captured,
// then executed; a pop that leaves elements adds a step reading the new end
// value through the store's single registered read port. A list of N elements
// is captured and executed, then each element is read and then emitted.
// Reset (rst_n low, asynchronous) empties the queue; store contents are kept.
// A result waits in the output register while the next item is captured;
// execution stalls only when that register is still full.
module double_ended_queue_ring_unit #(
    parameter int DEPTH = 16,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int OUT_W = ((96 + CNT_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [31:0]      s_axis_tdata,  // [31:0] data_in
    input  logic [2:0]       s_axis_tuser,  // [2:0] kind
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,  // data_out, fill_count, front_value,
                                            // back_value, zero fill
    output logic [1:0]       m_axis_tuser,  // [1:0] status
    output logic             m_axis_tlast
);
    import deq_pkg::*;

    cmd_t               cmd;
    sts_t               sts;
    logic [1:0]         out_status;
    logic signed [31:0] out_data;
    logic [CNT_W-1:0]   out_count;
    logic signed [31:0] out_front;
    logic signed [31:0] out_back;

    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    deq_datapath #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_kind    (s_axis_tuser),
        .in_data    (signed'(s_axis_tdata)),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_status (out_status),
        .out_data   (out_data),
        .out_count  (out_count),
        .out_front  (out_front),
        .out_back   (out_back),
        .out_last   (m_axis_tlast)
    );

    // Pack the result fields, lowest first
    assign s_axis_tready = cmd.ready;
    assign m_axis_tuser  = out_status;
    assign m_axis_tdata  = {{(OUT_W - 96 - CNT_W){1'b0}}, out_back, out_front,
                            out_count, out_data};

    // One item at a time: no capture right after a capture
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while previous item in flight");

    // A full report comes only from a full store
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == STATUS_FULL)) |-> (out_count == CNT_W'(DEPTH)))
        else $error("full status with store not full");

    // An empty report shows an empty store with zero ends
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == STATUS_EMPTY))
        |-> ((out_count == '0) && (out_front == '0) && (out_back == '0) && m_axis_tlast))
        else $error("empty status with inconsistent result");

    // Fill count never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_count <= CNT_W'(DEPTH)))
        else $error("fill count beyond depth");

endmodule

### rtl/deq_ctrl.sv
// Controller state machine of the double-ended queue ring unit.
// Sequences capture, execution, end-value fetch and list walk.
// Depends on deq_pkg for the state type and command/status structs.
module deq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  deq_pkg::sts_t sts,
    output deq_pkg::cmd_t cmd
);
    import deq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.out_free)
                begin
                    if (sts.op_fetch)
                    begin
                        state_next = ST_FETCH;
                    end
                    else if (sts.op_list)
                    begin
                        state_next = ST_LIST_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FETCH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LIST_RD:
            begin
                state_next = ST_LIST_OUT;
            end
            ST_LIST_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.list_last ? ST_IDLE : ST_LIST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                cmd.take  = in_valid;
            end
            ST_DECODE:
            begin
                cmd.exec = sts.out_free;
            end
            ST_FETCH:
            begin
                cmd.fetch = sts.out_free;
            end
            ST_LIST_RD:
            begin
                cmd.list_rd = 1'b1;
            end
            ST_LIST_OUT:
            begin
                cmd.list_emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/deq_datapath.sv
// Datapath of the double-ended queue ring unit: ring store, head index,
// element count, cached end values and the result register.
// Depends on deq_pkg for kind and status codes and command/status structs.
module deq_datapath #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  deq_pkg::cmd_t      cmd,
    output deq_pkg::sts_t      sts,
    input  logic [2:0]         in_kind,
    input  logic signed [31:0] in_data,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [1:0]         out_status,
    output logic signed [31:0] out_data,
    output logic [CNT_W-1:0]   out_count,
    output logic signed [31:0] out_front,
    output logic signed [31:0] out_back,
    output logic               out_last
);
    import deq_pkg::*;

    localparam int SUM_W = CNT_W + 1;

    // Ring store
    logic [31:0] mem [DEPTH];

    logic [2:0]         kind_reg;
    logic signed [31:0] din_reg;
    logic [IDX_W-1:0]   head_reg,  head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic signed [31:0] front_reg, front_next;
    logic signed [31:0] back_reg,  back_next;
    logic [IDX_W-1:0]   idx_reg,   idx_next;
    logic signed [31:0] pend_reg,  pend_next;
    logic               fsel_reg,  fsel_next;
    logic [31:0]        rd_data_reg;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;

    logic               out_valid_reg, out_valid_next;
    logic               load_out;
    logic [1:0]         ost_next;
    logic signed [31:0] odata_next;
    logic [CNT_W-1:0]   ocount_next;
    logic signed [31:0] ofront_next;
    logic signed [31:0] oback_next;
    logic               olast_next;
    logic [1:0]         ost_reg;
    logic signed [31:0] odata_reg;
    logic [CNT_W-1:0]   ocount_reg;
    logic signed [31:0] ofront_reg;
    logic signed [31:0] oback_reg;
    logic               olast_reg;

    logic               is_full;
    logic               is_empty;
    logic               out_free;
    logic [IDX_W-1:0]   head_dec;

    // Slot of base plus offset, wrapped once around the ring
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign out_free = !out_valid_reg || out_ready;
    assign head_dec = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - IDX_W'(1);

    // Report status to the controller
    always_comb
    begin
        sts.out_free  = out_free;
        sts.op_fetch  = ((kind_reg == KIND_POP_FRONT) || (kind_reg == KIND_POP_BACK))
                        && (count_reg >= CNT_W'(2));
        sts.op_list   = (kind_reg == KIND_LIST) && !is_empty;
        sts.list_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    end

    // Compute next values of the queue state and the result
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        front_next  = front_reg;
        back_next   = back_reg;
        idx_next    = idx_reg;
        pend_next   = pend_reg;
        fsel_next   = fsel_reg;
        mem_we      = 1'b0;
        mem_waddr   = head_reg;
        rd_en       = 1'b0;
        rd_addr     = head_reg;
        load_out    = 1'b0;
        ost_next    = STATUS_OK;
        odata_next  = '0;
        ocount_next = count_reg;
        ofront_next = front_reg;
        oback_next  = back_reg;
        olast_next  = 1'b1;

        if (cmd.exec)
        begin
            case (kind_reg)
                KIND_PUSH_FRONT:
                begin
                    load_out = 1'b1;
                    if (is_full)
                    begin
                        ost_next = STATUS_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = head_dec;
                        head_next  = head_dec;
                        count_next = count_reg + CNT_W'(1);
                        front_next = din_reg;
                        if (is_empty)
                        begin
                            back_next = din_reg;
                        end
                    end
                end
                KIND_PUSH_BACK:
                begin
                    load_out = 1'b1;
                    if (is_full)
                    begin
                        ost_next = STATUS_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = wrap_add(head_reg, count_reg);
                        count_next = count_reg + CNT_W'(1);
                        back_next  = din_reg;
                        if (is_empty)
                        begin
                            front_next = din_reg;
                        end
                    end
                end
                KIND_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        load_out = 1'b1;
                        ost_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        pend_next  = front_reg;
                        head_next  = wrap_add(head_reg, CNT_W'(1));
                        count_next = count_reg - CNT_W'(1);
                        fsel_next  = 1'b1;
                        if (count_reg == CNT_W'(1))
                        begin
                            // Last element leaves: both ends read as zero
                            front_next = '0;
                            back_next  = '0;
                            load_out   = 1'b1;
                            odata_next = front_reg;
                        end
                        else
                        begin
                            rd_en   = 1'b1;
                            rd_addr = wrap_add(head_reg, CNT_W'(1));
                        end
                    end
                end
                KIND_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        load_out = 1'b1;
                        ost_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        pend_next  = back_reg;
                        count_next = count_reg - CNT_W'(1);
                        fsel_next  = 1'b0;
                        if (count_reg == CNT_W'(1))
                        begin
                            front_next = '0;
                            back_next  = '0;
                            load_out   = 1'b1;
                            odata_next = back_reg;
                        end
                        else
                        begin
                            rd_en   = 1'b1;
                            rd_addr = wrap_add(head_reg, count_reg - CNT_W'(2));
                        end
                    end
                end
                KIND_LIST:
                begin
                    idx_next = '0;
                    if (is_empty)
                    begin
                        load_out = 1'b1;
                        ost_next = STATUS_EMPTY;
                    end
                end
                default:
                begin
                    // Unused kinds: plain ok result, store untouched
                    load_out = 1'b1;
                end
            endcase
            ocount_next = count_next;
            ofront_next = front_next;
            oback_next  = back_next;
        end
        else if (cmd.fetch)
        begin
            // Install the new end value read from the store
            if (fsel_reg)
            begin
                front_next = signed'(rd_data_reg);
            end
            else
            begin
                back_next = signed'(rd_data_reg);
            end
            load_out    = 1'b1;
            odata_next  = pend_reg;
            ofront_next = front_next;
            oback_next  = back_next;
        end
        else if (cmd.list_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = wrap_add(head_reg, CNT_W'(idx_reg));
        end
        else if (cmd.list_emit)
        begin
            load_out   = 1'b1;
            odata_next = signed'(rd_data_reg);
            olast_next = sts.list_last;
            idx_next   = idx_reg + IDX_W'(1);
        end
    end

    assign out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            front_reg     <= '0;
            back_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture item and working payload
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            kind_reg <= in_kind;
            din_reg  <= in_data;
        end
        idx_reg  <= idx_next;
        pend_reg <= pend_next;
        fsel_reg <= fsel_next;
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            ost_reg    <= ost_next;
            odata_reg  <= odata_next;
            ocount_reg <= ocount_next;
            ofront_reg <= ofront_next;
            oback_reg  <= oback_next;
            olast_reg  <= olast_next;
        end
    end

    // Write and read the ring store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= din_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = ost_reg;
    assign out_data   = odata_reg;
    assign out_count  = ocount_reg;
    assign out_front  = ofront_reg;
    assign out_back   = oback_reg;
    assign out_last   = olast_reg;

endmodule
